// ===== rtl/cmc_pkg.sv =====
// Shared types, constants and small calendar helpers for the calendar
// millisecond converter. No dependencies; every file but cmc_if.sv uses it.
package cmc_pkg;

  localparam int unsigned NUM_STAGES = 9;

  localparam logic CMD_COMPOSE   = 1'b0;
  localparam logic CMD_DECOMPOSE = 1'b1;

  localparam logic [48:0] MAX_COUNT   = 49'd315537897599999;
  localparam logic [13:0] MAX_YEAR    = 14'd9999;
  localparam logic [48:0] MS_PER_DAY  = 49'd86400000;
  localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [26:0] MS_PER_MIN  = 27'd60000;
  localparam logic [26:0] MS_PER_SEC  = 27'd1000;
  localparam logic [16:0] DAY_SHR10   = 17'd84375;   // MS_PER_DAY / 1024
  localparam logic [21:0] DAYS_400Y   = 22'd146097;
  localparam logic [17:0] DAYS_100Y   = 18'd36524;
  localparam logic [15:0] DAYS_4Y     = 16'd1461;
  localparam logic [10:0] DAYS_1Y     = 11'd365;

  // Reciprocals for the constant divisions. All but the divide-by-100 one are
  // rounded down, so those estimates are never above the true quotient. The
  // divide-by-100 one is rounded up, but over any 14-bit operand its excess
  // stays far below one hundredth, so that quotient comes out exact.
  localparam logic [20:0] RCP_DAY   = 21'd1628906;  // 2^37 / 84375
  localparam logic [12:0] RCP_400Y  = 13'd7349;     // 2^30 / 146097
  localparam logic [15:0] RCP_HOUR  = 16'd38177;    // 2^30 / 28125
  localparam logic [16:0] RCP_MIN   = 17'd71582;    // 2^27 / 1875
  localparam logic [13:0] RCP_SEC   = 14'd8388;     // 2^20 / 125
  localparam logic [13:0] RCP_4Y    = 14'd11483;    // 2^24 / 1461
  localparam logic [12:0] RCP_100   = 13'd5243;     // 2^19 / 100, rounded up

  typedef struct packed {
    logic        cmd;
    logic        ok;
    logic [13:0] y;
    logic [3:0]  mo;
    logic [4:0]  d;
    logic [4:0]  h;
    logic [5:0]  mi;
    logic [5:0]  s;
    logic [9:0]  ms;
    logic [48:0] cnt;
    logic [2:0]  wd;
    logic        leap;
    logic [7:0]  q100;
    logic [7:0]  p100;
    logic [5:0]  p400;
    logic [21:0] dby;
    logic [26:0] tms;
    logic [21:0] days;
    logic [42:0] xprod;
    logic [18:0] rx;
    logic [26:0] rem;
    logic [4:0]  n400;
    logic [21:0] rh;
    logic [17:0] r400;
    logic [1:0]  n100;
    logic [15:0] r100;
    logic [15:0] rm;
    logic [4:0]  n4;
    logic [10:0] r4;
    logic [1:0]  n1;
    logic [8:0]  doy;
  } pipe_t;

  // Days in the year before the first of month m, common year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    return cum_days(m) + 9'((leap && (m > 4'd2)) ? 1 : 0);
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Since 8 is 1 modulo 7, summing octal digits keeps the residue.
  function automatic logic [2:0] mod7(input logic [21:0] v);
    logic [23:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    w  = {2'b00, v};
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(w[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    return (s3 == 4'd7) ? 3'd0 : s3[2:0];
  endfunction

endpackage

// ===== rtl/cmc_if.sv =====
// Valid/ready channel interfaces for the converter's input and result beats.
// Uses no package; payload fields are plain vectors.
interface cmc_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [13:0]        in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic [4:0]         in_hour;
  logic [5:0]         in_minute;
  logic [5:0]         in_second;
  logic [9:0]         in_milli;
  logic signed [49:0] in_count;

  modport source (output valid, command, in_year, in_month, in_day, in_hour,
                  in_minute, in_second, in_milli, in_count, input ready);
  modport sink (input valid, command, in_year, in_month, in_day, in_hour,
                in_minute, in_second, in_milli, in_count, output ready);
endinterface

interface cmc_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [48:0] out_count;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [9:0]  out_milli;
  logic [2:0]  weekday;

  modport source (output valid, valid_res, out_count, out_year, out_month, out_day,
                  out_hour, out_minute, out_second, out_milli, weekday, input ready);
  modport sink (input valid, valid_res, out_count, out_year, out_month, out_day,
                out_hour, out_minute, out_second, out_milli, weekday, output ready);
endinterface

// ===== rtl/calendar_millisecond_converter_top.sv =====
// Top level of the calendar millisecond converter: a nine-stage pipeline.
// Depends on cmc_pkg and the channel interfaces in cmc_if.sv.
//
//  channel  dir  beat contents
//  in_i     in   command, date-time fields, signed count
//  out_o    out  valid_res, count, date-time fields, weekday
//
// One beat can be accepted every cycle while the output is not stalled. The
// depth comes from the chain of constant divisions (day, 400/100/4/1-year
// cycles, hour, minute, second), with the time-of-day ones beside the year ones.
// Reset clears only the stage valid bits. Each stage holds while the one
// after it is full and stalled, so a stalled output fills bubbles upstream.
module calendar_millisecond_converter_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  cmc_in_if.sink    in_i,
  cmc_out_if.source out_o
);

  localparam int unsigned NS = cmc_pkg::NUM_STAGES;

  cmc_pkg::pipe_t pipe_q [NS];
  cmc_pkg::pipe_t pipe_d [NS];
  logic [NS-1:0]  vld_q;
  logic [NS:0]    rdy;

  function automatic cmc_pkg::pipe_t st1(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [13:0]    pm1;
    logic [27:0]    t0;
    logic [27:0]    t1;
    logic [25:0]    t2;
    p     = pi;
    pm1   = p.y - 14'd1;
    t0    = 28'(p.y) * 28'(cmc_pkg::RCP_100);
    t1    = 28'(pm1) * 28'(cmc_pkg::RCP_100);
    t2    = 26'(pm1[13:2]) * 26'(cmc_pkg::RCP_100);
    p.q100  = 8'(t0 >> 19);
    p.p100  = 8'(t1 >> 19);
    p.p400  = 6'(t2 >> 19);
    p.xprod = 43'(p.cnt[48:27]) * 43'(cmc_pkg::RCP_DAY);
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st2(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [13:0]    hund;
    logic [13:0]    pm1;
    logic [4:0]     dim;
    logic [21:0]    qest;
    logic [39:0]    prod;
    p = pi;
    if (p.cmd == cmc_pkg::CMD_COMPOSE) begin
      hund   = 14'(p.q100) * 14'd100;
      p.leap = (p.y[1:0] == 2'd0) && ((p.y != hund) || (p.q100[1:0] == 2'd0));
      dim    = cmc_pkg::days_in_month(p.mo, p.leap);
      p.ok   = (p.y >= 14'd1) && (p.y <= cmc_pkg::MAX_YEAR) && (p.mo >= 4'd1) &&
               (p.mo <= 4'd12) && (p.d >= 5'd1) && (p.d <= dim) && (p.h <= 5'd23) &&
               (p.mi <= 6'd59) && (p.s <= 6'd59) && (p.ms <= 10'd999);
      pm1    = p.y - 14'd1;
      p.dby  = 22'(pm1) * 22'd365 + 22'(pm1[13:2]) - 22'(p.p100) + 22'(p.p400);
    end else begin
      qest   = 22'(p.xprod >> 20);
      prod   = 40'(qest) * 40'(cmc_pkg::DAY_SHR10);
      p.rx   = 19'(40'(p.cnt[48:10]) - prod);
      p.days = qest;
    end
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st3(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [1:0]     corr;
    logic [16:0]    remhi;
    p = pi;
    if (p.cmd == cmc_pkg::CMD_COMPOSE) begin
      p.days = p.dby + 22'(cmc_pkg::month_start(p.mo, p.leap)) + 22'(p.d) - 22'd1;
      p.tms  = 27'(p.h) * cmc_pkg::MS_PER_HOUR + 27'(p.mi) * cmc_pkg::MS_PER_MIN +
               27'(p.s) * cmc_pkg::MS_PER_SEC + 27'(p.ms);
    end else begin
      // The day estimate is at most three short; fix it with three compares.
      corr   = 2'(p.rx >= 19'd84375) + 2'(p.rx >= 19'd168750) +
               2'(p.rx >= 19'd253125);
      remhi  = 17'(p.rx - 19'(corr) * 19'(cmc_pkg::DAY_SHR10));
      p.days = p.days + 22'(corr);
      p.rem  = {remhi[16:0], p.cnt[9:0]};
    end
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st4(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [34:0]    t0;
    logic [34:0]    t1;
    p    = pi;
    p.wd = cmc_pkg::mod7(p.days);
    if (p.cmd == cmc_pkg::CMD_COMPOSE) begin
      p.cnt = 49'(p.days) * cmc_pkg::MS_PER_DAY + 49'(p.tms);
    end else begin
      t0     = 35'(p.days) * 35'(cmc_pkg::RCP_400Y);
      t1     = 35'(p.rem[26:7]) * 35'(cmc_pkg::RCP_HOUR);
      p.n400 = 5'(t0 >> 30);
      p.h    = 5'(t1 >> 30);
    end
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st5(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [21:0]    t;
    logic [22:0]    th;
    p  = pi;
    t  = p.days - 22'(p.n400) * cmc_pkg::DAYS_400Y;
    th = 23'(p.rem) - 23'(p.h) * 23'(cmc_pkg::MS_PER_HOUR);
    if (t >= cmc_pkg::DAYS_400Y) begin
      t      = t - cmc_pkg::DAYS_400Y;
      p.n400 = p.n400 + 5'd1;
    end
    if (th >= 23'(cmc_pkg::MS_PER_HOUR)) begin
      th  = th - 23'(cmc_pkg::MS_PER_HOUR);
      p.h = p.h + 5'd1;
    end
    if (p.cmd == cmc_pkg::CMD_DECOMPOSE) begin
      p.r400 = 18'(t);
      p.rh   = 22'(th);
    end else begin
      p.h = pi.h;
    end
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st6(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [33:0]    tm;
    logic [5:0]     me;
    logic [21:0]    r;
    p = pi;
    if (p.cmd == cmc_pkg::CMD_DECOMPOSE) begin
      p.n100 = 2'(p.r400 >= 18'd36524) + 2'(p.r400 >= 18'd73048) +
               2'(p.r400 >= 18'd109572);
      p.r100 = 16'(p.r400 - 18'(p.n100) * cmc_pkg::DAYS_100Y);
      tm     = 34'(p.rh[21:5]) * 34'(cmc_pkg::RCP_MIN);
      me     = 6'(tm >> 27);
      r      = p.rh - 22'(me) * 22'(cmc_pkg::MS_PER_MIN);
      if (r >= 22'(cmc_pkg::MS_PER_MIN)) begin
        r  = r - 22'(cmc_pkg::MS_PER_MIN);
        me = me + 6'd1;
      end
      p.mi = me;
      p.rm = 16'(r);
    end
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st7(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [29:0]    t4;
    logic [4:0]     n4e;
    logic [15:0]    r;
    logic [32:0]    ts;
    logic [5:0]     se;
    logic [15:0]    rs;
    p = pi;
    if (p.cmd == cmc_pkg::CMD_DECOMPOSE) begin
      t4  = 30'(p.r100) * 30'(cmc_pkg::RCP_4Y);
      n4e = 5'(t4 >> 24);
      r   = p.r100 - 16'(n4e) * cmc_pkg::DAYS_4Y;
      if (r >= cmc_pkg::DAYS_4Y) begin
        r   = r - cmc_pkg::DAYS_4Y;
        n4e = n4e + 5'd1;
      end
      p.n4 = n4e;
      p.r4 = 11'(r);
      ts   = 33'(p.rm[15:3]) * 33'(cmc_pkg::RCP_SEC);
      se   = 6'(ts >> 20);
      rs   = p.rm - 16'(se) * 16'(cmc_pkg::MS_PER_SEC);
      if (rs >= 16'(cmc_pkg::MS_PER_SEC)) begin
        rs = rs - 16'(cmc_pkg::MS_PER_SEC);
        se = se + 6'd1;
      end
      p.s  = se;
      p.ms = 10'(rs);
    end
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st8(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    p = pi;
    if (p.cmd == cmc_pkg::CMD_DECOMPOSE) begin
      p.n1   = 2'(p.r4 >= 11'd365) + 2'(p.r4 >= 11'd730) + 2'(p.r4 >= 11'd1095);
      p.doy  = 9'(p.r4 - 11'(p.n1) * cmc_pkg::DAYS_1Y);
      p.y    = 14'(p.n400) * 14'd400 + 14'(p.n100) * 14'd100 + 14'(p.n4) * 14'd4 +
               14'(p.n1) + 14'd1;
      // Last year of a four-year cycle is leap, unless it closes a century
      // that is not the last one of its 400-year cycle.
      p.leap = (p.n1 == 2'd3) && ((p.n4 != 5'd24) || (p.n100 == 2'd3));
    end
    return p;
  endfunction

  function automatic cmc_pkg::pipe_t st9(input cmc_pkg::pipe_t pi);
    cmc_pkg::pipe_t p;
    logic [3:0]     m;
    p = pi;
    if (p.cmd == cmc_pkg::CMD_DECOMPOSE) begin
      m = 4'd1;
      for (int k = 2; k <= 12; k++) begin
        if (p.doy >= cmc_pkg::month_start(4'(k), p.leap)) begin
          m = 4'(k);
        end
      end
      p.mo = m;
      p.d  = 5'(p.doy - cmc_pkg::month_start(m, p.leap) + 9'd1);
    end
    if (!p.ok) begin
      p.y   = '0;
      p.mo  = '0;
      p.d   = '0;
      p.h   = '0;
      p.mi  = '0;
      p.s   = '0;
      p.ms  = '0;
      p.cnt = '0;
      p.wd  = '0;
    end
    return p;
  endfunction

  always_comb begin
    cmc_pkg::pipe_t p;
    p      = '0;
    p.cmd  = in_i.command;
    p.y    = in_i.in_year;
    p.mo   = in_i.in_month;
    p.d    = in_i.in_day;
    p.h    = in_i.in_hour;
    p.mi   = in_i.in_minute;
    p.s    = in_i.in_second;
    p.ms   = in_i.in_milli;
    p.cnt  = in_i.in_count[48:0];
    p.ok   = (in_i.command == cmc_pkg::CMD_COMPOSE) ||
             (!in_i.in_count[49] && (in_i.in_count[48:0] <= cmc_pkg::MAX_COUNT));
    pipe_d[0] = st1(p);
    pipe_d[1] = st2(pipe_q[0]);
    pipe_d[2] = st3(pipe_q[1]);
    pipe_d[3] = st4(pipe_q[2]);
    pipe_d[4] = st5(pipe_q[3]);
    pipe_d[5] = st6(pipe_q[4]);
    pipe_d[6] = st7(pipe_q[5]);
    pipe_d[7] = st8(pipe_q[6]);
    pipe_d[8] = st9(pipe_q[7]);
  end

  // A stage may load when it is empty or when its beat moves on.
  always_comb begin
    rdy[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_i.valid) begin
      pipe_q[0] <= pipe_d[0];
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k] && vld_q[k-1]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign in_i.ready       = rdy[0];
  assign out_o.valid      = vld_q[NS-1];
  assign out_o.valid_res  = pipe_q[NS-1].ok;
  assign out_o.out_count  = pipe_q[NS-1].cnt;
  assign out_o.out_year   = pipe_q[NS-1].y;
  assign out_o.out_month  = pipe_q[NS-1].mo;
  assign out_o.out_day    = pipe_q[NS-1].d;
  assign out_o.out_hour   = pipe_q[NS-1].h;
  assign out_o.out_minute = pipe_q[NS-1].mi;
  assign out_o.out_second = pipe_q[NS-1].s;
  assign out_o.out_milli  = pipe_q[NS-1].ms;
  assign out_o.weekday    = pipe_q[NS-1].wd;

  a_in_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q))
    else $error("input stalled while the pipeline has an empty stage");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.valid_res) |->
      (out_o.out_count == '0) && (out_o.out_year == '0) && (out_o.weekday == '0))
    else $error("invalid result carries nonzero fields");

  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.valid_res) |->
      (out_o.out_month >= 4'd1) && (out_o.out_month <= 4'd12) &&
      (out_o.out_day >= 5'd1) && (out_o.weekday <= 3'd6) &&
      (out_o.out_hour <= 5'd23) && (out_o.out_milli <= 10'd999))
    else $error("valid result with an out-of-range field");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && rdy[1]) |=> vld_q[1])
    else $error("beat lost between the first two stages");

endmodule

// ===== test/calendar_millisecond_converter_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class for the calendar millisecond converter testbench.
// Depends on cmc_pkg for the command codes and the count limit.
package calendar_millisecond_converter_tb_pkg;

  typedef struct packed {
    logic        command;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  milli;
    logic [49:0] count;
  } date_req_t;

  typedef struct packed {
    logic        valid_res;
    logic [48:0] count;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  milli;
    logic [2:0]  weekday;
  } date_res_t;

  function automatic bit leap_year(longint unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint unsigned month_days(longint unsigned y, longint unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Straightforward calendar arithmetic, no reciprocal tricks.
  function automatic date_res_t convert_date(date_req_t r);
    date_res_t o;
    longint unsigned days, cnt, rem, p, y, mo;
    o = '0;
    if (r.command == cmc_pkg::CMD_COMPOSE) begin
      if (r.year < 1 || r.year > 9999 || r.month < 1 || r.month > 12) return o;
      if (r.day < 1 || r.day > month_days(r.year, r.month)) return o;
      if (r.hour > 23 || r.minute > 59 || r.second > 59 || r.milli > 999) return o;
      p = r.year - 1;
      days = p * 365 + p / 4 - p / 100 + p / 400;
      for (longint unsigned m = 1; m < r.month; m++) days += month_days(r.year, m);
      days += r.day - 1;
      cnt = days * 86400000 + r.hour * 3600000 + r.minute * 60000 + r.second * 1000
            + r.milli;
      o = '{1'b1, cnt[48:0], r.year, r.month, r.day, r.hour, r.minute, r.second,
            r.milli, 3'((cnt / 86400000) % 7)};
    end else begin
      if (r.count[49]) return o;
      cnt = r.count;
      if (cnt > cmc_pkg::MAX_COUNT) return o;
      days = cnt / 86400000;
      rem = cnt % 86400000;
      // Walk years, then months; day of year is zero based.
      y = 1 + 400 * (days / 146097);
      days = days % 146097;
      while (days >= (leap_year(y) ? 366 : 365)) begin
        days -= leap_year(y) ? 366 : 365;
        y++;
      end
      mo = 1;
      while (days >= month_days(y, mo)) begin
        days -= month_days(y, mo);
        mo++;
      end
      o = '{1'b1, cnt[48:0], 14'(y), 4'(mo), 5'(days + 1), 5'(rem / 3600000),
            6'((rem / 60000) % 60), 6'((rem / 1000) % 60), 10'(rem % 1000),
            3'((cnt / 86400000) % 7)};
    end
    return o;
  endfunction

  class date_scoreboard;
    date_res_t pending[$];
    int errors;

    function void note_request(date_req_t r);
      pending.push_back(convert_date(r));
    endfunction

    function void check_result(date_res_t got);
      date_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== test/calendar_millisecond_converter_top_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the calendar millisecond converter: directed and random
// beats under varying back-pressure. Depends on cmc_pkg, cmc_if and the tb package.
module calendar_millisecond_converter_top_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int send_idle_pct = 11;
  int recv_idle_pct = 47;
  longint cycles = 0;
  calendar_millisecond_converter_tb_pkg::date_scoreboard board = new();

  cmc_in_if  in_ch();
  cmc_out_if out_ch();

  calendar_millisecond_converter_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.command, in_ch.in_year, in_ch.in_month, in_ch.in_day, in_ch.in_hour,
     in_ch.in_minute, in_ch.in_second, in_ch.in_milli, in_ch.in_count} = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: check on handshake, then choose next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        board.check_result('{out_ch.valid_res, out_ch.out_count, out_ch.out_year,
                             out_ch.out_month, out_ch.out_day, out_ch.out_hour,
                             out_ch.out_minute, out_ch.out_second, out_ch.out_milli,
                             out_ch.weekday});
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(calendar_millisecond_converter_tb_pkg::date_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= r.command;
    in_ch.in_year   <= r.year;
    in_ch.in_month  <= r.month;
    in_ch.in_day    <= r.day;
    in_ch.in_hour   <= r.hour;
    in_ch.in_minute <= r.minute;
    in_ch.in_second <= r.second;
    in_ch.in_milli  <= r.milli;
    in_ch.in_count  <= r.count;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_request(r);
  endtask

  task automatic send_compose(int y, int mo, int d, int h, int mi, int s, int ms);
    calendar_millisecond_converter_tb_pkg::date_req_t r;
    r = '0;
    r.command = cmc_pkg::CMD_COMPOSE;
    r = '{cmc_pkg::CMD_COMPOSE, 14'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), 10'(ms),
          50'($urandom)};
    send_beat(r);
  endtask

  task automatic send_decompose(logic [49:0] c);
    calendar_millisecond_converter_tb_pkg::date_req_t r;
    r = '{cmc_pkg::CMD_DECOMPOSE, 14'($urandom), 4'($urandom), 5'($urandom),
          5'($urandom), 6'($urandom), 6'($urandom), 10'($urandom), c};
    send_beat(r);
  endtask

  function automatic logic [49:0] random_count();
    return 50'({$urandom, $urandom} % (50'(cmc_pkg::MAX_COUNT) + 1));
  endfunction

  task automatic random_beat();
    calendar_millisecond_converter_tb_pkg::date_req_t r;
    logic [127:0] raw;
    int pick;
    int y;
    pick = $urandom_range(9);
    if (pick < 4) begin
      y = ($urandom_range(3) == 0) ? 400 * $urandom_range(1, 24) : $urandom_range(1, 9999);
      send_compose(y, $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(23),
                   $urandom_range(59), $urandom_range(59), $urandom_range(999));
    end else if (pick < 8) begin
      send_decompose(random_count());
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(r)-1:0];
      send_beat(r);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: epoch, limits, leap rules and out-of-range fields.
    send_compose(1, 1, 1, 0, 0, 0, 0);
    send_compose(9999, 12, 31, 23, 59, 59, 999);
    send_compose(2000, 2, 29, 12, 30, 30, 500);
    send_compose(1900, 2, 29, 0, 0, 0, 0);
    send_compose(2024, 2, 29, 0, 0, 0, 0);
    send_compose(2023, 4, 31, 0, 0, 0, 0);
    send_compose(0, 1, 1, 0, 0, 0, 0);
    send_compose(10000, 1, 1, 0, 0, 0, 0);
    send_compose(16383, 15, 31, 31, 63, 63, 1023);
    send_compose(5, 0, 1, 0, 0, 0, 0);
    send_compose(5, 13, 0, 0, 0, 0, 0);
    send_compose(5, 3, 1, 24, 0, 0, 0);
    send_compose(5, 3, 1, 0, 60, 0, 0);
    send_compose(5, 3, 1, 0, 0, 60, 0);
    send_compose(5, 3, 1, 0, 0, 0, 1000);
    send_decompose(50'd0);
    send_decompose(50'(cmc_pkg::MAX_COUNT));
    send_decompose(50'(cmc_pkg::MAX_COUNT) + 1);
    send_decompose({1'b1, 49'd0});
    send_decompose({50{1'b1}});
    send_decompose({1'b0, {49{1'b1}}});
    send_decompose(50'd86400000 * 50'd1460);
    send_decompose(50'd86400000 * 50'd146096 + 50'd1);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 11 : 0;
      for (int i = 0; i < 380; i++) random_beat();
    end
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
